// ----- hw/rtl/shabs_pkg.sv -----
// Shared types, constants and round constants for the SHA-256 byte stream hasher.
// Used by shabs_round and sha256_byte_stream_hasher; depends on nothing else.

package shabs_pkg;

    localparam int WORD_W     = 32;
    localparam int BLOCK_W    = 6;    // byte position in a 64-byte block
    localparam int ROUND_W    = 6;    // 64 rounds
    localparam int SLOT_W     = 3;    // eight hash words
    localparam int COUNT_W    = 61;
    localparam int SCHED_N    = 16;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 40;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t [7:0] hash_vec_t;    // index 0 is word a / H0

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    localparam logic [0:0] CMD_ABSORB = 1'b0;
    localparam logic [0:0] CMD_FINISH = 1'b1;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [BLOCK_W-1:0] LENGTH_POS = BLOCK_W'(56);
    localparam logic [BLOCK_W-1:0] BLOCK_END  = BLOCK_W'(63);

    localparam word_t INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

// ----- hw/rtl/shabs_round.sv -----
// One SHA-256 compression round plus message schedule expansion.
// Depends on shabs_pkg; reused by the top level for every round.

module shabs_round
(
    input  shabs_pkg::hash_vec_t work,
    input  shabs_pkg::word_t     k,
    input  shabs_pkg::word_t     w0,       // W[t], used by this round
    input  shabs_pkg::word_t     w1,       // W[t+1]
    input  shabs_pkg::word_t     w9,       // W[t+9]
    input  shabs_pkg::word_t     w14,      // W[t+14]
    output shabs_pkg::word_t     w_new,    // W[t+16], built beside the round
    output shabs_pkg::hash_vec_t work_out
);

    function automatic shabs_pkg::word_t rotr(input shabs_pkg::word_t x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    shabs_pkg::word_t s0;
    shabs_pkg::word_t s1;
    shabs_pkg::word_t big_s0;
    shabs_pkg::word_t big_s1;
    shabs_pkg::word_t ch;
    shabs_pkg::word_t maj;
    shabs_pkg::word_t t1;
    shabs_pkg::word_t t2;

    always_comb
    begin
        // next schedule word runs in parallel with the round adders
        s0    = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
        s1    = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
        w_new = s1 + w9 + s0 + w0;

        big_s1 = rotr(work[4], 6) ^ rotr(work[4], 11) ^ rotr(work[4], 25);
        big_s0 = rotr(work[0], 2) ^ rotr(work[0], 13) ^ rotr(work[0], 22);
        ch     = (work[4] & work[5]) ^ (~work[4] & work[6]);
        maj    = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
        t1     = work[7] + big_s1 + ch + k + w0;
        t2     = big_s0 + maj;

        work_out[7] = work[6];
        work_out[6] = work[5];
        work_out[5] = work[4];
        work_out[4] = work[3] + t1;
        work_out[3] = work[2];
        work_out[2] = work[1];
        work_out[1] = work[0];
        work_out[0] = t1 + t2;
    end

endmodule

// ----- hw/rtl/sha256_byte_stream_hasher.sv -----
// Top level of the SHA-256 byte stream hasher: stream ports, sequencer, buffers.
// Depends on shabs_pkg and shabs_round.
//
//  channel  | dir | tdata                              | tuser     | tlast
//  s_axis   | in  | [7:0] data_byte                    | [0] cmd   | -
//  m_axis   | out | [31:0] digest_word, [34:32] index  | -         | last_word
//
// An absorb item shifts in one byte. Every 64th byte starts a compression: 64 rounds
// through the single round unit, then a fold of all eight words into the chaining
// hash with one adder; no new byte is taken until that fold ends.
// A finish item shifts in padding one byte a cycle up to the block end (a second
// block when the 0x80 mark lands at byte 56 or later), compresses, then hands out
// eight words, one a cycle while m_axis_tready is high.
// s_axis_tready is high only while idle. rst_n clears control and loads the initial hash.

module sha256_byte_stream_hasher
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] cmd

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
    output logic        m_axis_tlast    // last_word
);

    shabs_pkg::state_t state_reg, state_next;

    logic [shabs_pkg::BLOCK_W-1:0] fill_reg, fill_next;
    logic [shabs_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [shabs_pkg::ROUND_W-1:0] round_reg, round_next;
    logic [shabs_pkg::SLOT_W-1:0]  slot_reg, slot_next;
    logic pad_reg, pad_next;
    logic first_reg, first_next;
    logic extra_reg, extra_next;
    logic final_reg, final_next;

    shabs_pkg::hash_vec_t chain_reg, chain_next;
    shabs_pkg::hash_vec_t work_reg, work_next;
    shabs_pkg::word_t     sched_reg [shabs_pkg::SCHED_N];
    shabs_pkg::word_t     sched_next [shabs_pkg::SCHED_N];

    logic        out_valid_reg, out_valid_next;
    shabs_pkg::word_t out_word_reg, out_word_next;
    logic [shabs_pkg::SLOT_W-1:0] out_index_reg, out_index_next;
    logic        out_last_reg, out_last_next;

    logic        in_fire;
    logic        out_free;
    logic        shift_en;
    logic [7:0]  shift_byte;
    logic [7:0]  pad_byte;
    logic [63:0] bit_len;
    logic [63:0] len_shifted;

    shabs_pkg::word_t     w_new;
    shabs_pkg::hash_vec_t round_out;

    // schedule window holds W[t] .. W[t+15] during round t
    shabs_round u_round
    (
        .work     (work_reg),
        .k        (shabs_pkg::ROUND_K[round_reg]),
        .w0       (sched_reg[0]),
        .w1       (sched_reg[1]),
        .w9       (sched_reg[9]),
        .w14      (sched_reg[14]),
        .w_new    (w_new),
        .work_out (round_out)
    );

    assign s_axis_tready = (state_reg == shabs_pkg::ST_IDLE);
    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign out_free      = ~out_valid_reg | m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_index_reg, out_word_reg};
    assign m_axis_tlast  = out_last_reg;

    // Length bytes go out most significant first from byte 56 on
    assign bit_len     = {count_reg, 3'b000};
    assign len_shifted = bit_len >> {~fill_reg[2:0], 3'b000};

    always_comb
    begin
        priority if (first_reg)
            pad_byte = shabs_pkg::PAD_MARK;
        else if (fill_reg >= shabs_pkg::LENGTH_POS && !extra_reg)
            pad_byte = len_shifted[7:0];
        else
            pad_byte = 8'h00;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            shabs_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_axis_tuser == shabs_pkg::CMD_FINISH)
                        state_next = shabs_pkg::ST_PAD;
                    else if (fill_reg == shabs_pkg::BLOCK_END)
                        state_next = shabs_pkg::ST_ROUND;
                end
            end
            shabs_pkg::ST_PAD:
            begin
                if (fill_reg == shabs_pkg::BLOCK_END)
                    state_next = shabs_pkg::ST_ROUND;
            end
            shabs_pkg::ST_ROUND:
            begin
                if (&round_reg)
                    state_next = shabs_pkg::ST_FOLD;
            end
            shabs_pkg::ST_FOLD:
            begin
                if (&slot_reg)
                begin
                    priority if (pad_reg && final_reg)
                        state_next = shabs_pkg::ST_EMIT;
                    else if (pad_reg)
                        state_next = shabs_pkg::ST_PAD;
                    else
                        state_next = shabs_pkg::ST_IDLE;
                end
            end
            shabs_pkg::ST_EMIT:
            begin
                if (out_free && &slot_reg)
                    state_next = shabs_pkg::ST_IDLE;
            end
            default:
                state_next = shabs_pkg::ST_IDLE;
        endcase
    end

    // Datapath and counters
    always_comb
    begin
        fill_next      = fill_reg;
        count_next     = count_reg;
        round_next     = round_reg;
        slot_next      = slot_reg;
        pad_next       = pad_reg;
        first_next     = first_reg;
        extra_next     = extra_reg;
        final_next     = final_reg;
        chain_next     = chain_reg;
        work_next      = work_reg;
        sched_next     = sched_reg;
        out_valid_next = out_valid_reg & ~m_axis_tready;
        out_word_next  = out_word_reg;
        out_index_next = out_index_reg;
        out_last_next  = out_last_reg;
        shift_en       = 1'b0;
        shift_byte     = pad_byte;

        unique case (state_reg)
            shabs_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_axis_tuser == shabs_pkg::CMD_FINISH)
                    begin
                        pad_next   = 1'b1;
                        first_next = 1'b1;
                        final_next = 1'b0;
                        extra_next = (fill_reg >= shabs_pkg::LENGTH_POS);
                    end
                    else
                    begin
                        shift_en   = 1'b1;
                        shift_byte = s_axis_tdata;
                        fill_next  = fill_reg + 1'b1;
                        count_next = count_reg + 1'b1;
                        pad_next   = 1'b0;
                        final_next = 1'b0;
                        work_next  = chain_reg;
                    end
                end
            end
            shabs_pkg::ST_PAD:
            begin
                shift_en   = 1'b1;
                fill_next  = fill_reg + 1'b1;
                first_next = 1'b0;
                work_next  = chain_reg;
                if (fill_reg == shabs_pkg::BLOCK_END)
                begin
                    extra_next = 1'b0;
                    final_next = ~extra_reg;
                end
            end
            shabs_pkg::ST_ROUND:
            begin
                work_next  = round_out;
                round_next = round_reg + 1'b1;
                for (int i = 0; i < shabs_pkg::SCHED_N - 1; i++)
                    sched_next[i] = sched_reg[i+1];
                sched_next[shabs_pkg::SCHED_N-1] = w_new;
            end
            shabs_pkg::ST_FOLD:
            begin
                // rotate both vectors so one adder serves all eight words
                for (int i = 0; i < 7; i++)
                begin
                    chain_next[i] = chain_reg[i+1];
                    work_next[i]  = work_reg[i+1];
                end
                chain_next[7] = chain_reg[0] + work_reg[0];
                work_next[7]  = work_reg[0];
                slot_next     = slot_reg + 1'b1;
            end
            shabs_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = chain_reg[0];
                    out_index_next = slot_reg;
                    out_last_next  = &slot_reg;
                    for (int i = 0; i < 7; i++)
                        chain_next[i] = chain_reg[i+1];
                    // refill with the initial value as each word leaves
                    chain_next[7] = shabs_pkg::INIT_HASH[slot_reg];
                    slot_next     = slot_reg + 1'b1;
                    if (&slot_reg)
                    begin
                        count_next = '0;
                        pad_next   = 1'b0;
                        final_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (shift_en)
        begin
            for (int i = 0; i < shabs_pkg::SCHED_N - 1; i++)
                sched_next[i] = {sched_reg[i][23:0], sched_reg[i+1][31:24]};
            sched_next[shabs_pkg::SCHED_N-1] =
                {sched_reg[shabs_pkg::SCHED_N-1][23:0], shift_byte};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= shabs_pkg::ST_IDLE;
            fill_reg      <= '0;
            count_reg     <= '0;
            round_reg     <= '0;
            slot_reg      <= '0;
            pad_reg       <= 1'b0;
            first_reg     <= 1'b0;
            extra_reg     <= 1'b0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= shabs_pkg::INIT_HASH[i];
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            round_reg     <= round_next;
            slot_reg      <= slot_next;
            pad_reg       <= pad_next;
            first_reg     <= first_next;
            extra_reg     <= extra_next;
            final_reg     <= final_next;
            out_valid_reg <= out_valid_next;
            chain_reg     <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg      <= work_next;
        sched_reg     <= sched_next;
        out_word_reg  <= out_word_next;
        out_index_reg <= out_index_next;
        out_last_reg  <= out_last_next;
    end

endmodule
